>>> hw/rtl/avsfp_pkg.sv
`default_nettype none

package avsfp_pkg;

    localparam int unsigned DIM_W      = 14;
    localparam int unsigned CODED_W    = 15;
    localparam int unsigned RATE_W     = 4;
    localparam int unsigned HDR_KEEP   = 47;
    localparam int unsigned W_LSB      = 33;
    localparam int unsigned H_LSB      = 19;
    localparam int unsigned R_LSB      = 6;
    localparam int unsigned SIZE_ROUND = 15;

    localparam logic [31:0] CODE_PIC_I  = 32'h0000_01B3;
    localparam logic [31:0] CODE_PIC_PB = 32'h0000_01B6;
    localparam logic [31:0] CODE_SEQ    = 32'h0000_01B0;
    localparam logic [23:0] CODE_PREFIX = 24'h00_0001;

    localparam logic [3:0]        HDR_LEN  = 4'd8;
    localparam logic [RATE_W-1:0] RATE_MAX = 4'd13;
    localparam logic [RATE_W-1:0] RATE_DEF = 4'd1;

    typedef enum logic {
        ACT_DATA   = 1'b0,
        ACT_MARKER = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        END_NONE   = 2'd0,
        END_SCAN   = 2'd1,
        END_MARKER = 2'd2
    } t_end_kind;

    typedef struct packed {
        logic [31:0]         window;
        logic                is_key;
        logic                has_bytes;
        logic [3:0]          hdr_left;
        logic [HDR_KEEP-1:0] hdr_bits;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [RATE_W-1:0]   rate;
    } t_content;

endpackage

`default_nettype wire

>>> hw/rtl/avsfp_content.sv
`default_nettype none

module avsfp_content (
    input  avsfp_pkg::t_content i_state,
    input  logic [31:0]         i_bytes,
    input  logic [2:0]          i_count,
    output avsfp_pkg::t_content o_state
);
    import avsfp_pkg::*;

    function automatic t_content content_byte(t_content s, logic [7:0] b);
        t_content          n;
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        logic [RATE_W-1:0] r;
        n = s;
        n.has_bytes = 1'b1;
        if (s.window[31:8] == CODE_PREFIX) begin
            if (s.window == CODE_PIC_I) begin
                n.is_key = 1'b1;
            end else if (s.window == CODE_SEQ) begin
                n.hdr_left = HDR_LEN;
                n.hdr_bits = '0;
            end
        end
        if (n.hdr_left != 4'd0) begin
            n.hdr_bits = {n.hdr_bits[HDR_KEEP-9:0], b};
            n.hdr_left = n.hdr_left - 4'd1;
            if (n.hdr_left == 4'd0) begin
                w = n.hdr_bits[W_LSB +: DIM_W];
                h = n.hdr_bits[H_LSB +: DIM_W];
                r = n.hdr_bits[R_LSB +: RATE_W];
                if (w != '0 && h != '0) begin
                    if (r == '0 || r > RATE_MAX) begin
                        r = RATE_DEF;
                    end
                    n.width  = w;
                    n.height = h;
                    n.rate   = r;
                end
            end
        end
        n.window = {s.window[23:0], b};
        return n;
    endfunction

    // Byte lanes in stream order; lane 0 takes the oldest byte at the top of the word.
    t_content w_lane [5];

    assign w_lane[0] = i_state;

    for (genvar j = 0; j < 4; j++) begin : g_lane
        assign w_lane[j+1] = (3'(j) < i_count)
                           ? content_byte(w_lane[j], i_bytes[31-8*j -: 8])
                           : w_lane[j];
    end

    assign o_state = w_lane[4];

endmodule

`default_nettype wire

>>> hw/rtl/avsfp_result.sv
`default_nettype none

module avsfp_result (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  avsfp_pkg::t_end_kind                i_kind,
    input  avsfp_pkg::t_content                 i_post,
    input  logic                                i_ready,
    output logic                                o_can_load,
    output logic                                o_valid,
    output logic [1:0]                          o_frame_end_kind,
    output logic                                o_intra_frame,
    output logic [avsfp_pkg::DIM_W-1:0]         o_picture_width,
    output logic [avsfp_pkg::DIM_W-1:0]         o_picture_height,
    output logic [avsfp_pkg::CODED_W-1:0]       o_padded_width,
    output logic [avsfp_pkg::CODED_W-1:0]       o_padded_height,
    output logic [avsfp_pkg::RATE_W-1:0]        o_frame_rate_code
);
    import avsfp_pkg::*;

    logic               r_valid;
    logic [1:0]         r_kind;
    logic               r_key;
    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic [CODED_W-1:0] r_cwidth;
    logic [CODED_W-1:0] r_cheight;
    logic [RATE_W-1:0]  r_rate;

    logic               w_ended;
    logic [CODED_W-1:0] w_wsum;
    logic [CODED_W-1:0] w_hsum;

    assign o_can_load = !r_valid || i_ready;
    assign w_ended    = (i_kind != END_NONE);
    assign w_wsum     = {1'b0, i_post.width}  + CODED_W'(SIZE_ROUND);
    assign w_hsum     = {1'b0, i_post.height} + CODED_W'(SIZE_ROUND);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kind <= i_kind;
            if (w_ended) begin
                r_key     <= i_post.is_key;
                r_width   <= i_post.width;
                r_height  <= i_post.height;
                r_cwidth  <= {w_wsum[CODED_W-1:4], 4'b0000};
                r_cheight <= {w_hsum[CODED_W-1:4], 4'b0000};
                r_rate    <= i_post.rate;
            end else begin
                r_key     <= 1'b0;
                r_width   <= '0;
                r_height  <= '0;
                r_cwidth  <= '0;
                r_cheight <= '0;
                r_rate    <= '0;
            end
        end
    end

    assign o_valid           = r_valid;
    assign o_frame_end_kind  = r_kind;
    assign o_intra_frame     = r_key;
    assign o_picture_width   = r_width;
    assign o_picture_height  = r_height;
    assign o_padded_width    = r_cwidth;
    assign o_padded_height   = r_cheight;
    assign o_frame_rate_code = r_rate;

endmodule

`default_nettype wire

>>> hw/rtl/avs_video_frame_parser_core.sv
// Channel   Direction  Handshake                    Payload
// in        input      i_in_valid / o_in_ready      i_action, i_data_byte
// out       output     o_out_valid / i_out_ready    o_frame_end_kind .. o_frame_rate_code
// cfg       input      i_cfg_we, no wait            i_cfg_wdata (complete_frames)
//
// Every input transfer yields exactly one output transfer, presented from the next cycle on.
// One input transfer per cycle unless stalled; the single output register sets this.
// A marker pushes up to four delayed bytes through the content lanes in that same cycle.
// Reset is synchronous and active low and needs no clearing pass.
// While the output register is full and not taken, o_in_ready is low.

`default_nettype none

module avs_video_frame_parser_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_action,
    input  logic [7:0]                          i_data_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_frame_end_kind,
    output logic                                o_intra_frame,
    output logic [avsfp_pkg::DIM_W-1:0]         o_picture_width,
    output logic [avsfp_pkg::DIM_W-1:0]         o_picture_height,
    output logic [avsfp_pkg::CODED_W-1:0]       o_padded_width,
    output logic [avsfp_pkg::CODED_W-1:0]       o_padded_height,
    output logic [avsfp_pkg::RATE_W-1:0]        o_frame_rate_code,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_wdata
);
    import avsfp_pkg::*;

    logic        r_complete_frames;
    logic [31:0] r_recent;
    logic [2:0]  r_fill;
    logic        r_pic_found;
    t_content    r_content;

    logic [31:0] n_recent;
    logic [2:0]  n_fill;
    logic        n_pic_found;
    t_content    n_content;

    logic        w_accept;
    logic        w_marker;
    logic [31:0] w_bytes;
    logic [2:0]  w_count;
    t_content    w_post;
    t_end_kind   w_kind;
    logic [31:0] w_shifted;
    logic        w_pic;
    logic        w_seq;

    assign w_accept  = i_in_valid && o_in_ready;
    assign w_marker  = (t_action'(i_action) == ACT_MARKER);
    assign w_shifted = {r_recent[23:0], i_data_byte};
    assign w_pic     = (w_shifted == CODE_PIC_I) || (w_shifted == CODE_PIC_PB);
    assign w_seq     = (w_shifted == CODE_SEQ);

    always_comb begin
        w_bytes = r_recent;
        w_count = 3'd0;
        if (w_marker) begin
            w_count = r_fill;
            case (r_fill)
                3'd1:    w_bytes = {r_recent[7:0], 24'h0};
                3'd2:    w_bytes = {r_recent[15:0], 16'h0};
                3'd3:    w_bytes = {r_recent[23:0], 8'h0};
                default: w_bytes = r_recent;
            endcase
        end else if (r_fill == 3'd4) begin
            w_count = 3'd1;
        end
    end

    avsfp_content u_content (
        .i_state (r_content),
        .i_bytes (w_bytes),
        .i_count (w_count),
        .o_state (w_post)
    );

    always_comb begin
        w_kind      = END_NONE;
        n_recent    = w_shifted;
        n_fill      = (r_fill == 3'd4) ? r_fill : r_fill + 3'd1;
        n_pic_found = r_pic_found;
        n_content   = w_post;
        if (w_marker) begin
            w_kind      = w_post.has_bytes ? END_MARKER : END_NONE;
            n_recent    = '1;
            n_fill      = 3'd0;
            n_pic_found = 1'b0;
        end else if (!r_complete_frames) begin
            if (!r_pic_found) begin
                n_pic_found = w_pic;
            end else if (w_pic || w_seq) begin
                w_kind      = END_SCAN;
                n_pic_found = w_pic;
            end
        end
        if (w_marker || w_kind == END_SCAN) begin
            n_content.window    = '1;
            n_content.is_key    = 1'b0;
            n_content.has_bytes = 1'b0;
            n_content.hdr_left  = 4'd0;
            n_content.hdr_bits  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_complete_frames <= 1'b0;
        end else if (i_cfg_we) begin
            r_complete_frames <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent    <= '1;
            r_fill      <= 3'd0;
            r_pic_found <= 1'b0;
            r_content   <= '{window: '1, default: '0};
        end else if (w_accept) begin
            r_recent    <= n_recent;
            r_fill      <= n_fill;
            r_pic_found <= n_pic_found;
            r_content   <= n_content;
        end
    end

    avsfp_result u_result (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (w_accept),
        .i_kind            (w_kind),
        .i_post            (w_post),
        .i_ready           (i_out_ready),
        .o_can_load        (o_in_ready),
        .o_valid           (o_out_valid),
        .o_frame_end_kind  (o_frame_end_kind),
        .o_intra_frame     (o_intra_frame),
        .o_picture_width   (o_picture_width),
        .o_picture_height  (o_picture_height),
        .o_padded_width    (o_padded_width),
        .o_padded_height   (o_padded_height),
        .o_frame_rate_code (o_frame_rate_code)
    );

endmodule

`default_nettype wire
